/* rtl/core/mexp_pkg.sv */
// mexp_pkg: shared constants, types and command codes for the modular
// exponentiation block. No dependencies; imported by every module in rtl/core.
package mexp_pkg;

    // operand width inside the datapath, and width of the port fields
    localparam int OPERAND_WIDTH = 32;
    localparam int FIELD_WIDTH   = 32;
    localparam int CNT_WIDTH     = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

    typedef logic [OPERAND_WIDTH-1:0] t_op;
    typedef logic [OPERAND_WIDTH:0]   t_op_ext;
    typedef logic [FIELD_WIDTH-1:0]   t_field;
    typedef logic [CNT_WIDTH-1:0]     t_cnt;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_INIT,
        S_RED,
        S_RED_WB,
        S_CHECK,
        S_ACC_INIT,
        S_ACC,
        S_ACC_WB,
        S_SQ_INIT,
        S_SQ,
        S_SQ_WB,
        S_DONE
    } t_state;

    // datapath commands
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_RED_INIT,
        DP_ACC_INIT,
        DP_SQ_INIT,
        DP_STEP,
        DP_WB_BASE,
        DP_WB_ACC,
        DP_WB_SQ
    } t_dp_cmd;

    // datapath status toward the controller
    typedef struct packed {
        logic mod_zero;
        logic exp_zero;
        logic exp_bit0;
        logic exp_rest_zero;
        logic cnt_last;
    } t_dp_stat;

endpackage

/* rtl/core/mexp_dp.sv */
// mexp_dp: datapath with operand registers, bit-serial modular multiplier
// (double then add, one multiplier bit per cycle) and result ports.
// Depends on mexp_pkg.
module mexp_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mexp_pkg::t_dp_cmd i_cmd,
    input  mexp_pkg::t_field i_base,
    input  mexp_pkg::t_field i_exponent,
    input  mexp_pkg::t_field i_modulus,
    output mexp_pkg::t_dp_stat o_stat,
    output mexp_pkg::t_field o_power_mod,
    output logic             o_modulus_zero
);
    import mexp_pkg::*;

    t_op  r_base, n_base;
    t_op  r_exp, n_exp;
    t_op  r_mod, n_mod;
    t_op  r_acc, n_acc;
    t_op  r_mm, n_mm;
    t_op  r_mult, n_mult;
    t_op  r_mcand, n_mcand;
    t_cnt r_cnt, n_cnt;

    t_op_ext mod_ext;
    t_op_ext dbl_sum;
    t_op     dbl;
    t_op     addend;
    t_op_ext add_sum;
    t_op     step_res;
    t_op     acc_red;

    // one multiplier step: mm = (2*mm + bit*mcand) mod m
    always_comb begin
        mod_ext  = {1'b0, r_mod};
        dbl_sum  = {r_mm, 1'b0};
        dbl      = (dbl_sum >= mod_ext) ? t_op'(dbl_sum - mod_ext) : t_op'(dbl_sum);
        addend   = r_mult[OPERAND_WIDTH-1] ? r_mcand : '0;
        add_sum  = {1'b0, dbl} + {1'b0, addend};
        step_res = (add_sum >= mod_ext) ? t_op'(add_sum - mod_ext) : t_op'(add_sum);
    end

    // running product reduced: it only reaches m when it is 1 and m is 1
    assign acc_red = (r_acc >= r_mod) ? '0 : r_acc;

    // register updates by command
    always_comb begin
        n_base  = r_base;
        n_exp   = r_exp;
        n_mod   = r_mod;
        n_acc   = r_acc;
        n_mm    = r_mm;
        n_mult  = r_mult;
        n_mcand = r_mcand;
        n_cnt   = r_cnt;
        unique case (i_cmd)
            DP_LOAD: begin
                n_base = t_op'(i_base);
                n_exp  = t_op'(i_exponent);
                n_mod  = t_op'(i_modulus);
                n_acc  = t_op'(1);
            end
            DP_RED_INIT: begin
                // base mod m: shift base bits in with an addend of one
                n_mm    = '0;
                n_mult  = r_base;
                n_mcand = t_op'(1);
                n_cnt   = '0;
            end
            DP_ACC_INIT: begin
                n_mm    = '0;
                n_mult  = r_base;
                n_mcand = acc_red;
                n_cnt   = '0;
            end
            DP_SQ_INIT: begin
                n_mm    = '0;
                n_mult  = r_base;
                n_mcand = r_base;
                n_cnt   = '0;
            end
            DP_STEP: begin
                n_mm   = step_res;
                n_mult = {r_mult[OPERAND_WIDTH-2:0], 1'b0};
                n_cnt  = r_cnt + t_cnt'(1);
            end
            DP_WB_BASE: n_base = r_mm;
            DP_WB_ACC:  n_acc  = r_mm;
            DP_WB_SQ: begin
                n_base = r_mm;
                n_exp  = {1'b0, r_exp[OPERAND_WIDTH-1:1]};
            end
            default: ;
        endcase
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_exp   <= n_exp;
        r_mod   <= n_mod;
        r_acc   <= n_acc;
        r_mm    <= n_mm;
        r_mult  <= n_mult;
        r_mcand <= n_mcand;
        r_cnt   <= n_cnt;
    end

    // status toward the controller
    always_comb begin
        o_stat.mod_zero      = (r_mod == '0);
        o_stat.exp_zero      = (r_exp == '0);
        o_stat.exp_bit0      = r_exp[0];
        o_stat.exp_rest_zero = (r_exp[OPERAND_WIDTH-1:1] == '0);
        o_stat.cnt_last      = (r_cnt == t_cnt'(OPERAND_WIDTH - 1));
    end

    // result word
    assign o_modulus_zero = (r_mod == '0);
    assign o_power_mod    = o_modulus_zero ? '0 : t_field'(r_acc);

    logic unused_rst;
    assign unused_rst = i_rst_n;

endmodule

/* rtl/core/mexp_ctrl.sv */
// mexp_ctrl: controller state machine that sequences base reduction and the
// square-and-multiply loop over the exponent bits. Depends on mexp_pkg.
module mexp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    output logic               o_valid,
    input  mexp_pkg::t_dp_stat i_stat,
    output mexp_pkg::t_dp_cmd  o_cmd
);
    import mexp_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = DP_NOP;
        busy    = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd   = DP_LOAD;
                    n_state = S_RED_INIT;
                end
            end
            S_RED_INIT: begin
                if (i_stat.mod_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd   = DP_RED_INIT;
                    n_state = S_RED;
                end
            end
            S_RED: begin
                o_cmd = DP_STEP;
                if (i_stat.cnt_last) n_state = S_RED_WB;
            end
            S_RED_WB: begin
                o_cmd   = DP_WB_BASE;
                n_state = S_CHECK;
            end
            // examine the lowest remaining exponent bit
            S_CHECK: begin
                if (i_stat.exp_zero) begin
                    n_state = S_DONE;
                end else if (i_stat.exp_bit0) begin
                    n_state = S_ACC_INIT;
                end else begin
                    n_state = S_SQ_INIT;
                end
            end
            S_ACC_INIT: begin
                o_cmd   = DP_ACC_INIT;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd = DP_STEP;
                if (i_stat.cnt_last) n_state = S_ACC_WB;
            end
            S_ACC_WB: begin
                // last exponent bit: the final square is not needed
                o_cmd   = DP_WB_ACC;
                n_state = i_stat.exp_rest_zero ? S_DONE : S_SQ_INIT;
            end
            S_SQ_INIT: begin
                o_cmd   = DP_SQ_INIT;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd = DP_STEP;
                if (i_stat.cnt_last) n_state = S_SQ_WB;
            end
            S_SQ_WB: begin
                o_cmd   = DP_WB_SQ;
                n_state = S_CHECK;
            end
            S_DONE: begin
                o_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/core/modular_exponentiation.sv */
// modular_exponentiation: top level, base^exponent mod modulus by
// right-to-left square-and-multiply. Depends on mexp_pkg, mexp_ctrl, mexp_dp.
//
//   channel | handshake          | ports
//   --------+--------------------+---------------------------------------------
//   input   | start & !busy      | i_base, i_exponent, i_modulus
//   result  | o_valid (1 cycle)  | o_power_mod, o_modulus_zero
//
// One item at a time. Base reduction runs an init state, one multiplier step
// per operand bit and a write-back; each exponent bit then costs a check state
// plus modular multiplies of that same form: one multiply for a zero bit,
// two for a one bit, none for the square after the top set bit. After the
// strobe the block returns to idle, where the next word is taken.
// A zero modulus skips the reduction and strobes with the flag set.
// Reset is synchronous, active low, and returns the controller to idle.
// The result word stays on its ports until the next word is taken; the receiver cannot stall.
module modular_exponentiation (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  mexp_pkg::t_field i_base,
    input  mexp_pkg::t_field i_exponent,
    input  mexp_pkg::t_field i_modulus,
    output logic             o_valid,
    output mexp_pkg::t_field o_power_mod,
    output logic             o_modulus_zero
);
    import mexp_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer
    mexp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // operand registers and modular multiplier
    mexp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_base         (i_base),
        .i_exponent     (i_exponent),
        .i_modulus      (i_modulus),
        .o_stat         (dp_stat),
        .o_power_mod    (o_power_mod),
        .o_modulus_zero (o_modulus_zero)
    );

endmodule

/* dv/modular_exponentiation_tb.sv */
// modular_exponentiation_tb: self-checking bench for modular_exponentiation, which
// predicts base^exponent mod modulus per word and checks each strobed result.
// Depends on mexp_pkg and the modular_exponentiation top level in rtl/core.
module modular_exponentiation_tb;
    import mexp_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE_WAIT  = 64;
    localparam int MAX_REPORTS  = 10;
    // time limit for roughly 300 words at the worst case, taken three times over
    localparam int RUN_LIMIT    = 42_000_000;

    typedef struct packed {
        t_field power_mod;
        logic   modulus_zero;
    } t_power_word;

    logic   i_clk      = 1'b0;
    logic   i_rst_n    = 1'b0;
    logic   start      = 1'b0;
    t_field i_base     = '0;
    t_field i_exponent = '0;
    t_field i_modulus  = '0;
    logic   busy;
    logic   o_valid;
    t_field o_power_mod;
    logic   o_modulus_zero;

    t_power_word expected_powers[$];
    int          mismatch_count  = 0;
    int          sender_idle_pct = 0;

    modular_exponentiation u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_base         (i_base),
        .i_exponent     (i_exponent),
        .i_modulus      (i_modulus),
        .o_valid        (o_valid),
        .o_power_mod    (o_power_mod),
        .o_modulus_zero (o_modulus_zero)
    );

    // clock generation
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // right-to-left square-and-multiply; 64-bit products never overflow
    function automatic t_power_word predict_power(t_field base_in, t_field exponent_in,
                                                  t_field modulus_in);
        t_power_word word;
        logic [63:0] acc;
        logic [63:0] square;
        logic [63:0] m;
        t_field      bits;
        word = '0;
        // zero modulus wins over every other case
        if (modulus_in == '0) begin
            word.modulus_zero = 1'b1;
            return word;
        end
        m      = 64'(modulus_in);
        acc    = 64'd1;
        square = 64'(base_in) % m;
        bits   = exponent_in;
        // zero exponent leaves acc at 1, even for a modulus of one
        while (bits != '0) begin
            if (bits[0]) begin
                acc = ((acc % m) * square) % m;
            end
            square = (square * square) % m;
            bits   = bits >> 1;
        end
        word.power_mod = acc[FIELD_WIDTH-1:0];
        return word;
    endfunction

    // random operands, biased toward the corners of each field
    function automatic void draw_operands(output t_field base_out, output t_field exponent_out,
                                          output t_field modulus_out);
        case ($urandom_range(19))
            0:       modulus_out = '0;
            1:       modulus_out = 32'd1;
            2, 3:    modulus_out = t_field'($urandom_range(255, 2));
            4:       modulus_out = 32'hFFFF_FFFF - t_field'($urandom_range(15));
            5:       modulus_out = t_field'(1) << $urandom_range(31);
            default: modulus_out = t_field'($urandom);
        endcase
        case ($urandom_range(9))
            0:       base_out = '0;
            1:       base_out = '1;
            2:       base_out = modulus_out;
            default: base_out = t_field'($urandom);
        endcase
        case ($urandom_range(9))
            0:       exponent_out = '0;
            1:       exponent_out = '1;
            2, 3:    exponent_out = t_field'($urandom_range(15));
            4, 5:    exponent_out = t_field'($urandom) >> $urandom_range(31, 1);
            default: exponent_out = t_field'($urandom);
        endcase
    endfunction

    // present one word and hold it until the block takes it
    task automatic send_word(input t_field base_in, input t_field exponent_in,
                             input t_field modulus_in);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_base     <= base_in;
        i_exponent <= exponent_in;
        i_modulus  <= modulus_in;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        // queue the expectation behind the older ones
        expected_powers = {expected_powers,
                           predict_power(base_in, exponent_in, modulus_in)};
    endtask

    // drop start and hold off until every pending result is back
    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_powers.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // result checking, oldest expectation first
    always @(posedge i_clk) begin
        t_power_word want;
        if (i_rst_n && o_valid) begin
            if (expected_powers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected result word: power_mod %h modulus_zero %b",
                             o_power_mod, o_modulus_zero);
                end
            end else begin
                want = expected_powers.pop_front();
                if (o_power_mod !== want.power_mod || o_modulus_zero !== want.modulus_zero) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("result word mismatch: power_mod exp %h got %h, %s %b got %b",
                                 want.power_mod, o_power_mod, "modulus_zero exp",
                                 want.modulus_zero, o_modulus_zero);
                    end
                end
            end
        end
    end

    // corners of each field and the special cases
    task automatic test_special_cases();
        sender_idle_pct = 0;
        // zero exponent, including a modulus of one
        send_word(32'd5,          32'd0,          32'd7);
        send_word(32'd123,        32'd0,          32'd1);
        send_word(32'd0,          32'd0,          32'd1);
        send_word(32'hFFFF_FFFF,  32'd0,          32'hFFFF_FFFF);
        // zero modulus, also over a zero exponent
        send_word(32'd3,          32'd5,          32'd0);
        send_word(32'd0,          32'd0,          32'd0);
        send_word(32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd0);
        // zero base with a nonzero exponent
        send_word(32'd0,          32'd1,          32'd13);
        send_word(32'd0,          32'hFFFF_FFFF,  32'hFFFF_FFFF);
        // modulus of one with a nonzero exponent
        send_word(32'd7,          32'd3,          32'd1);
        // base equal to, just below or above the modulus
        send_word(32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFE,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_word(32'd13,         32'd13,         32'd13);
        send_word(32'h1234_5678,  32'd1,          32'd1000);
        send_word(32'hFFFF_FFFF,  32'd1,          32'hFFFF_FFFB);
        // long exponents and a top bit on its own
        send_word(32'd2,          32'd31,         32'hFFFF_FFFF);
        send_word(32'd2,          32'd32,         32'hFFFF_FFFF);
        send_word(32'hDEAD_BEEF,  32'h8000_0000,  32'hFFFF_FFFB);
        send_word(32'hAAAA_AAAA,  32'h5555_5555,  32'h7FFF_FFFF);
        // power-of-two and tiny moduli
        send_word(32'd3,          32'hFFFF_FFFF,  32'h8000_0000);
        send_word(32'd2,          32'd10,         32'd1024);
        send_word(32'd1,          32'hFFFF_FFFF,  32'd2);
    endtask

    // random words at a given sender idle rate
    task automatic test_random_items(input int word_count, input int idle_pct);
        t_field base_val;
        t_field exponent_val;
        t_field modulus_val;
        sender_idle_pct = idle_pct;
        repeat (word_count) begin
            draw_operands(base_val, exponent_val, modulus_val);
            send_word(base_val, exponent_val, modulus_val);
        end
    endtask

    // sender goes quiet until the block has answered everything
    task automatic test_sender_pause();
        t_field base_val;
        t_field exponent_val;
        t_field modulus_val;
        sender_idle_pct = 0;
        repeat (4) begin
            repeat (2) begin
                draw_operands(base_val, exponent_val, modulus_val);
                send_word(base_val, exponent_val, modulus_val);
            end
            wait_results_drained();
        end
    endtask

    // test sequence
    initial begin
        repeat (RESET_CYCLES) begin
            @(posedge i_clk);
        end
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_cases();
        test_random_items(90, 10);
        test_sender_pause();
        test_random_items(90, 64);
        test_random_items(70, 0);
        wait_results_drained();
        repeat (SETTLE_WAIT) begin
            @(posedge i_clk);
        end
        if (mismatch_count == 0 && expected_powers.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // hang guard
    initial begin
        #RUN_LIMIT;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
